FILE: rtl/pixel_lut_point_operation_macros.svh
// assertion macros shared by the pixel lookup checker
// each macro expects clk and rst to exist in the calling scope
`ifndef PIXEL_LUT_POINT_OPERATION_MACROS_SVH
`define PIXEL_LUT_POINT_OPERATION_MACROS_SVH

// consequent must hold in the same cycle, ignored during reset
`define PLUT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("plut check failed: same-cycle rule");

// consequent must hold in the next cycle, ignored during reset
`define PLUT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plut check failed: next-cycle rule");

// same-cycle rule that is also checked around reset
`define PLUT_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("plut check failed: reset rule");

`endif

FILE: rtl/plut_pkg.sv
// ----------------------------------------------------------------------------
// plut_pkg
// Shared types and constants for the gray-level lookup point transform.
// ----------------------------------------------------------------------------
`default_nettype none

package plut_pkg;

  // pixel and table geometry
  localparam int PIXEL_BITS_DEFAULT = 8;
  localparam int PIX_W              = 8;
  localparam int TBL_DEPTH          = 256;
  localparam int TBL_AW             = 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int MODE_W     = 3;

  // stretch arithmetic: products fit 18 bits signed, their sum 19 bits,
  // and the numerator magnitude stays below 2^17
  localparam int PROD_W = 18;
  localparam int NUM_W  = 19;
  localparam int QUO_W  = 17;

  // register reset values
  localparam logic [PIX_W-1:0] LOWER_CLIP_RESET = 8'd0;
  localparam logic [PIX_W-1:0] UPPER_CLIP_RESET = 8'd128;
  localparam logic [PIX_W-1:0] IN_MIN_RESET     = 8'd0;
  localparam logic [PIX_W-1:0] IN_MAX_RESET     = 8'd255;
  localparam logic [PIX_W-1:0] OUT_MIN_RESET    = 8'd0;
  localparam logic [PIX_W-1:0] OUT_MAX_RESET    = 8'd255;

  // transform codes held in lut_mode
  typedef enum logic [MODE_W-1:0] {
    MODE_IDENTITY = 3'd0,
    MODE_INVERT   = 3'd1,
    MODE_SIGN     = 3'd2,
    MODE_CLIP     = 3'd3,
    MODE_FREE     = 3'd4,
    MODE_STRETCH  = 3'd5
  } lut_mode_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_MODE       = 3'd1,
    REG_LOWER_CLIP = 3'd2,
    REG_UPPER_CLIP = 3'd3,
    REG_IN_MIN     = 3'd4,
    REG_IN_MAX     = 3'd5,
    REG_OUT_MIN    = 3'd6,
    REG_OUT_MAX    = 3'd7
  } cfg_reg_t;

  // one slot of the stretch divider pipeline
  typedef struct packed {
    logic [PIX_W-1:0] rem;   // partial remainder
    logic [QUO_W-1:0] quo;   // dividend bits shifting out, quotient bits in
    logic             neg;   // quotient is negative
    logic [PIX_W-1:0] base;  // result of every transform but stretch
  } div_stage_t;

endpackage

`default_nettype wire

FILE: rtl/plut_table.sv
// ----------------------------------------------------------------------------
// plut_table
// Free-form lookup table: 256 x 8 synchronous memory with a registered read
// and per-entry valid bits so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module plut_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [plut_pkg::TBL_AW-1:0] wr_addr,
  input  logic [plut_pkg::PIX_W-1:0]  wr_data,
  input  logic                       rd_en,
  input  logic [plut_pkg::TBL_AW-1:0] rd_addr,
  output logic [plut_pkg::PIX_W-1:0]  rd_data
);

  logic [plut_pkg::PIX_W-1:0]     mem [plut_pkg::TBL_DEPTH];
  logic [plut_pkg::TBL_DEPTH-1:0] entry_valid;
  logic [plut_pkg::PIX_W-1:0]     rd_q;
  logic                           rd_valid;

  // memory array, one write and one read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // valid bits, cleared at once by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= entry_valid[rd_addr];
      end
    end
  end

  // never-written entries read as zero
  assign rd_data = rd_valid ? rd_q : '0;

endmodule

`default_nettype wire

FILE: rtl/plut_div.sv
// ----------------------------------------------------------------------------
// plut_div
// Pipelined restoring divider for the stretch transform: one quotient bit
// per stage, each stage holds its slot while its enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module plut_div (
  input  logic                         clk,
  input  logic [plut_pkg::QUO_W-1:0]   en,
  input  logic [plut_pkg::PIX_W-1:0]   divisor,
  input  plut_pkg::div_stage_t         stage_in,
  output plut_pkg::div_stage_t         stage_out
);

  plut_pkg::div_stage_t stage     [plut_pkg::QUO_W];
  plut_pkg::div_stage_t stage_next[plut_pkg::QUO_W];

  // one restoring step: bring down the next dividend bit and try a subtract
  function automatic plut_pkg::div_stage_t div_step(
    input plut_pkg::div_stage_t     s,
    input logic [plut_pkg::PIX_W-1:0] d
  );
    logic [plut_pkg::PIX_W:0] trial;
    logic [plut_pkg::PIX_W:0] diff;
    plut_pkg::div_stage_t     r;
    r     = s;
    trial = {s.rem, s.quo[plut_pkg::QUO_W-1]};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) begin
      r.rem = diff[plut_pkg::PIX_W-1:0];
      r.quo = {s.quo[plut_pkg::QUO_W-2:0], 1'b1};
    end else begin
      r.rem = trial[plut_pkg::PIX_W-1:0];
      r.quo = {s.quo[plut_pkg::QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // next value of every stage from the one before it
  always_comb begin
    stage_next[0] = div_step(stage_in, divisor);
    for (int k = 1; k < plut_pkg::QUO_W; k++) begin
      stage_next[k] = div_step(stage[k-1], divisor);
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < plut_pkg::QUO_W; k++) begin
      if (en[k]) begin
        stage[k] <= stage_next[k];
      end
    end
  end

  assign stage_out = stage[plut_pkg::QUO_W-1];

endmodule

`default_nettype wire

FILE: rtl/pixel_lut_point_operation.sv
// ----------------------------------------------------------------------------
// pixel_lut_point_operation
// Gray-level point transform: identity, inversion, sign, clip, free-form
// table and linear stretch, selected by configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on item_valid/item_stall with mode, pixel_in, table_index and
//   table_value. A pixel item (mode 0) yields one pixel_out on
//   result_valid/result_stall; a table-write item (mode 1) stores table_value
//   into the free-form table and yields nothing.
//   Registers are written through cfg_write/cfg_index/cfg_data while no item
//   is in flight.
//   A result reaches the output register after its item passes the table read
//   and products, numerator sum, 17 divider stages, clamp and select.
//   Throughput: one item per cycle while item_stall is low; the 17-stage
//   divider of the stretch path sets the depth.
//   A stalled receiver holds the output register; stages behind it keep
//   advancing into empty slots, so items are still taken until the pipe
//   is full. item_stall is high only when every stage holds an item and
//   result_stall is high.
//   Reset empties the pipeline, loads the register defaults and marks every
//   table entry unwritten (reads as zero) in the same cycle; no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_lut_point_operation #(
  parameter int PIXEL_BITS = plut_pkg::PIXEL_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_write,
  input  logic [plut_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [plut_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic                             mode,
  input  logic [plut_pkg::PIX_W-1:0]       pixel_in,
  input  logic [plut_pkg::TBL_AW-1:0]      table_index,
  input  logic [plut_pkg::PIX_W-1:0]       table_value,
  // results
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [plut_pkg::PIX_W-1:0]       pixel_out
);

  localparam int PW    = plut_pkg::PIX_W;
  localparam int N_STG = plut_pkg::QUO_W + 3;
  localparam int DIV_LO = 2;
  localparam int DIV_HI = DIV_LO + plut_pkg::QUO_W - 1;
  localparam logic [PW-1:0] PIX_MASK = PW'((1 << PIXEL_BITS) - 1);
  localparam logic [PW-1:0] PIX_HALF = PW'(1 << (PIXEL_BITS - 1));

  // configuration registers
  logic                        lut_enable;
  logic [plut_pkg::MODE_W-1:0] lut_mode;
  logic [PW-1:0]               lower_clip;
  logic [PW-1:0]               upper_clip;
  logic [PW-1:0]               stretch_in_min;
  logic [PW-1:0]               stretch_in_max;
  logic [PW-1:0]               stretch_out_min;
  logic [PW-1:0]               stretch_out_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      lut_enable      <= 1'b0;
      lut_mode        <= plut_pkg::MODE_IDENTITY;
      lower_clip      <= plut_pkg::LOWER_CLIP_RESET;
      upper_clip      <= plut_pkg::UPPER_CLIP_RESET;
      stretch_in_min  <= plut_pkg::IN_MIN_RESET;
      stretch_in_max  <= plut_pkg::IN_MAX_RESET;
      stretch_out_min <= plut_pkg::OUT_MIN_RESET;
      stretch_out_max <= plut_pkg::OUT_MAX_RESET;
    end else if (cfg_write) begin
      unique case (plut_pkg::cfg_reg_t'(cfg_index))
        plut_pkg::REG_ENABLE:     lut_enable      <= cfg_data[0];
        plut_pkg::REG_MODE:       lut_mode        <= cfg_data[plut_pkg::MODE_W-1:0];
        plut_pkg::REG_LOWER_CLIP: lower_clip      <= cfg_data;
        plut_pkg::REG_UPPER_CLIP: upper_clip      <= cfg_data;
        plut_pkg::REG_IN_MIN:     stretch_in_min  <= cfg_data;
        plut_pkg::REG_IN_MAX:     stretch_in_max  <= cfg_data;
        plut_pkg::REG_OUT_MIN:    stretch_out_min <= cfg_data;
        plut_pkg::REG_OUT_MAX:    stretch_out_max <= cfg_data;
        default:                  lut_enable      <= lut_enable;
      endcase
    end
  end

  // stretch terms that depend on configuration only
  logic signed [PW:0] din;
  logic signed [PW:0] dout;
  logic [PW-1:0]      divisor;
  logic [PW-1:0]      out_lo;
  logic [PW-1:0]      out_hi;
  logic               use_stretch;

  assign din  = $signed({1'b0, stretch_in_max}) - $signed({1'b0, stretch_in_min});
  assign dout = $signed({1'b0, stretch_out_max}) - $signed({1'b0, stretch_out_min});
  assign divisor = din[PW] ? PW'(-din) : din[PW-1:0];
  assign out_lo  = (stretch_out_min < stretch_out_max) ? stretch_out_min : stretch_out_max;
  assign out_hi  = (stretch_out_min < stretch_out_max) ? stretch_out_max : stretch_out_min;
  assign use_stretch = lut_enable &&
                       (plut_pkg::lut_mode_t'(lut_mode) == plut_pkg::MODE_STRETCH);

  // stage valid bits and per-stage advance enables
  logic [N_STG-1:0] stg_valid;
  logic [N_STG-1:0] en;

  always_comb begin
    for (int i = 0; i < N_STG; i++) begin
      // a stage may load unless it and every stage ahead are full and stalled
      en[i] = !result_stall || ((stg_valid & ({N_STG{1'b1}} << i)) != ({N_STG{1'b1}} << i));
    end
  end

  assign item_stall = !en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
    end else begin
      if (en[0]) begin
        stg_valid[0] <= item_valid && !mode;
      end
      for (int i = 1; i < N_STG; i++) begin
        if (en[i]) begin
          stg_valid[i] <= stg_valid[i-1];
        end
      end
    end
  end

  // first stage: table access and the two stretch products
  logic [PW-1:0]                     pix_m;
  logic signed [PW:0]                dp;
  logic signed [plut_pkg::PROD_W-1:0] prod_a_next;
  logic signed [plut_pkg::PROD_W-1:0] prod_b_next;
  logic signed [plut_pkg::PROD_W-1:0] prod_a;
  logic signed [plut_pkg::PROD_W-1:0] prod_b;
  logic [PW-1:0]                     pix1;
  logic [PW-1:0]                     tbl_data;

  assign pix_m = pixel_in & PIX_MASK;
  assign dp    = $signed({1'b0, pix_m}) - $signed({1'b0, stretch_in_min});
  assign prod_a_next = plut_pkg::PROD_W'(dp) * plut_pkg::PROD_W'(dout);
  assign prod_b_next = plut_pkg::PROD_W'($signed({1'b0, stretch_out_min})) *
                       plut_pkg::PROD_W'(din);

  plut_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (en[0] && item_valid && mode),
    .wr_addr (table_index),
    .wr_data (table_value),
    .rd_en   (en[0] && item_valid && !mode),
    .rd_addr (pix_m),
    .rd_data (tbl_data)
  );

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pix1   <= pix_m;
      prod_a <= prod_a_next;
      prod_b <= prod_b_next;
    end
  end

  // second stage: numerator sign and magnitude, all non-stretch transforms
  logic signed [plut_pkg::NUM_W-1:0] num;
  logic [plut_pkg::NUM_W-1:0]        num_mag;
  logic [PW-1:0]                     base;
  plut_pkg::div_stage_t              div_in_next;
  plut_pkg::div_stage_t              div_in;
  plut_pkg::div_stage_t              div_out;

  assign num     = plut_pkg::NUM_W'(prod_a) + plut_pkg::NUM_W'(prod_b);
  assign num_mag = num[plut_pkg::NUM_W-1] ? plut_pkg::NUM_W'(-num) : num;

  always_comb begin
    base = pix1;
    if (lut_enable) begin
      case (plut_pkg::lut_mode_t'(lut_mode))
        plut_pkg::MODE_INVERT: base = PIX_MASK - pix1;
        plut_pkg::MODE_SIGN:   base = (pix1 + PIX_HALF) & PIX_MASK;
        plut_pkg::MODE_CLIP: begin
          // when the bounds cross, pixels below lower_clip take it and all others take upper_clip
          if (pix1 < lower_clip) begin
            base = lower_clip;
          end else if (pix1 > upper_clip) begin
            base = upper_clip;
          end
        end
        plut_pkg::MODE_FREE:   base = tbl_data;
        default:               base = pix1;
      endcase
    end
  end

  always_comb begin
    div_in_next.rem  = '0;
    div_in_next.quo  = num_mag[plut_pkg::QUO_W-1:0];
    div_in_next.neg  = num[plut_pkg::NUM_W-1] ^ din[PW];
    div_in_next.base = base;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      div_in <= div_in_next;
    end
  end

  // divider stages
  plut_div u_div (
    .clk       (clk),
    .en        (en[DIV_HI:DIV_LO]),
    .divisor   (divisor),
    .stage_in  (div_in),
    .stage_out (div_out)
  );

  // last stage: clamp the quotient and pick the result
  logic [PW-1:0] stretch_val;
  logic [PW-1:0] result_next;
  logic [PW-1:0] result_q;

  always_comb begin
    if (din == '0) begin
      stretch_val = stretch_out_min;
    end else if (div_out.neg && (div_out.quo != '0)) begin
      stretch_val = out_lo;
    end else if (div_out.quo < plut_pkg::QUO_W'(out_lo)) begin
      stretch_val = out_lo;
    end else if (div_out.quo > plut_pkg::QUO_W'(out_hi)) begin
      stretch_val = out_hi;
    end else begin
      stretch_val = div_out.quo[PW-1:0];
    end
    result_next = use_stretch ? stretch_val : div_out.base;
  end

  always_ff @(posedge clk) begin
    if (en[N_STG-1]) begin
      result_q <= result_next;
    end
  end

  assign result_valid = stg_valid[N_STG-1];
  assign pixel_out    = result_q;

endmodule

`default_nettype wire

FILE: rtl/plut_checker.sv
// ----------------------------------------------------------------------------
// plut_checker
// Port-level checks for the pixel lookup transform, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pixel_lut_point_operation_macros.svh"

module plut_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_stall,
  input logic                        result_valid,
  input logic                        result_stall,
  input logic [plut_pkg::PIX_W-1:0]  pixel_out
);

  // a stalled result stays offered
  `PLUT_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)

  // a stalled result keeps its value
  `PLUT_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(pixel_out))

  // input is only held back when the output register is full and stalled
  `PLUT_ASSERT_NOW(a_no_spurious_stall, item_valid && (!result_valid || !result_stall), !item_stall)

  // reset empties the pipeline
  `PLUT_ASSERT_ALWAYS(a_reset_empties, $past(rst), !result_valid)

endmodule

bind pixel_lut_point_operation plut_checker u_plut_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .pixel_out    (pixel_out)
);

`default_nettype wire
